// ===== rtl/scbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short count bit packer: shared types and constants
// Request structs, the byte job handed from front to back, and code values.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int unsigned CountW   = 31;
  localparam int unsigned MaxBytes = 7;
  localparam int unsigned NumW     = 3;

  localparam logic        ActEncode = 1'b0;
  localparam logic        ActFlush  = 1'b1;

  localparam logic [7:0]  EscapeMark = 8'd254;

  // 2-bit codes for counts 0, 2 and 3
  localparam logic [3:0]  CodeZero  = 4'b0000;
  localparam logic [3:0]  CodeTwo   = 4'b0001;
  localparam logic [3:0]  CodeThree = 4'b0010;
  // 4-bit codes for counts 1, 4 and 5, and the escape
  localparam logic [3:0]  CodeOne   = 4'b0011;
  localparam logic [3:0]  CodeFour  = 4'b0111;
  localparam logic [3:0]  CodeFive  = 4'b1011;
  localparam logic [3:0]  CodeEsc   = 4'b1111;

  typedef struct packed {
    logic              action;
    logic [CountW-1:0] count_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [NumW-1:0]               num;
    logic [MaxBytes-1:0][7:0]      bytes;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

endpackage : scbp_pkg
`default_nettype wire

// ===== rtl/scbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short count bit packer: front end
// Classifies each request, updates the partial byte and emits a byte job.
// ----------------------------------------------------------------------------
module scbp_front import scbp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  output job_req_t      req
);

  logic [7:0]        partial_byte;
  logic [1:0]        bit_position;
  logic [7:0]        partial_byte_next;
  logic [1:0]        bit_position_next;

  logic [CountW-1:0] v;
  logic [3:0]        code;
  logic              is_long;
  logic              escape;
  logic [2:0]        offset;
  logic [15:0]       acc;
  logic [3:0]        total;
  logic              full_byte;
  logic              one_byte;
  logic              two_pre;
  job_t              job;

  always_comb begin
    v       = item.count_value;
    escape  = 1'b0;
    is_long = 1'b0;
    case (v)
      31'd0:   code = CodeZero;
      31'd2:   code = CodeTwo;
      31'd3:   code = CodeThree;
      31'd1:   begin code = CodeOne;  is_long = 1'b1; end
      31'd4:   begin code = CodeFour; is_long = 1'b1; end
      31'd5:   begin code = CodeFive; is_long = 1'b1; end
      default: begin code = CodeEsc;  is_long = 1'b1; escape = 1'b1; end
    endcase

    offset    = {bit_position, 1'b0};
    acc       = {8'd0, partial_byte} | ({12'd0, code} << offset);
    total     = {1'b0, offset} + (is_long ? 4'd4 : 4'd2);
    full_byte = total[3];
    one_byte  = (v < {{(CountW-8){1'b0}}, EscapeMark});
    two_pre   = (offset == 3'd6);

    job               = '0;
    job.bytes[0]      = acc[7:0];
    partial_byte_next = partial_byte;
    bit_position_next = bit_position;

    if (item.action == ActFlush) begin
      job.bytes[0]      = partial_byte;
      job.num           = (bit_position != 2'd0) ? 3'd1 : 3'd0;
      partial_byte_next = '0;
      bit_position_next = '0;
    end else if (escape) begin
      partial_byte_next = '0;
      bit_position_next = '0;
      if (two_pre) begin
        // straddled escape: top pair in first byte, high pair padded in second
        job.bytes[1] = acc[15:8];
        if (one_byte) begin
          job.bytes[2] = v[7:0];
          job.num      = 3'd3;
        end else begin
          job.bytes[2] = EscapeMark;
          job.bytes[3] = v[7:0];
          job.bytes[4] = v[15:8];
          job.bytes[5] = v[23:16];
          job.bytes[6] = {1'b0, v[30:24]};
          job.num      = 3'd7;
        end
      end else begin
        if (one_byte) begin
          job.bytes[1] = v[7:0];
          job.num      = 3'd2;
        end else begin
          job.bytes[1] = EscapeMark;
          job.bytes[2] = v[7:0];
          job.bytes[3] = v[15:8];
          job.bytes[4] = v[23:16];
          job.bytes[5] = {1'b0, v[30:24]};
          job.num      = 3'd6;
        end
      end
    end else begin
      job.num           = full_byte ? 3'd1 : 3'd0;
      partial_byte_next = full_byte ? acc[15:8] : acc[7:0];
      bit_position_next = total[2:1];
    end

    req.valid = accept && (job.num != 3'd0);
    req.job   = job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= '0;
      bit_position <= '0;
    end else if (accept) begin
      partial_byte <= partial_byte_next;
      bit_position <= bit_position_next;
    end
  end

endmodule : scbp_front
`default_nettype wire

// ===== rtl/scbp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short count bit packer: job queue
// Small FIFO of byte jobs between the front and back ends.
// ----------------------------------------------------------------------------
module scbp_queue import scbp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire job_req_t wr,
  output logic          full,
  input  wire logic     take,
  output logic          has_job,
  output job_t          head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == FullCnt);
  assign has_job = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_wr   = wr.valid && !full;
  assign do_rd   = take && has_job;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule : scbp_queue
`default_nettype wire

// ===== rtl/scbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short count bit packer: back end
// Holds one byte job and hands its bytes out one request at a time.
// ----------------------------------------------------------------------------
module scbp_back import scbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic has_job,
  input  wire job_t head,
  output logic      take,
  output logic      empty,
  input  wire logic pop,
  output out_item_t result
);

  job_t            job;
  logic [NumW-1:0] idx;
  logic            busy;
  logic            last;
  logic            advance;

  assign last    = (idx == job.num - 1'b1);
  assign advance = busy && pop;
  assign take    = has_job && (!busy || (advance && last));
  assign empty   = !busy;

  assign result = '{out_byte: job.bytes[idx], last_of_run: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      job  <= '0;
    end else if (take) begin
      job  <= head;
      idx  <= '0;
      busy <= 1'b1;
    end else if (advance) begin
      // drop the job after its final byte
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule : scbp_back
`default_nettype wire

// ===== rtl/short_count_bit_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Short count bit packer
// Packs counts into a byte stream in 2- and 4-bit codes plus escape bytes, LSB first.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item and push; a request is taken at a clock edge with
//   push high and full low. item.action selects encode or flush.
//   Output queue: while empty is low, result holds the oldest packed byte;
//   pop high at a clock edge takes it. last_of_run marks the final byte that
//   one input request produced. Requests that produce no byte give nothing.
// Timing:
//   The front end takes one request per cycle while full is low and turns it
//   into a byte job of 0 to 7 bytes. With the back end idle, the first byte
//   reaches result through the job queue, then the back end register; older
//   jobs still ahead of it delay it further. The back end delivers one byte
//   per cycle while pop is high, so the sustained rate is one request per
//   cycle while requests average at most one byte each.
//   Escape runs of up to 7 bytes are absorbed by the QueueDepth job queue.
// Reset and stall:
//   rst clears the partial byte, the fill point and the queue. If the
//   receiver stops popping, the job queue fills and full is raised; no
//   byte is lost.
// ----------------------------------------------------------------------------
module short_count_bit_packer import scbp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t item,
  input  wire logic     push,
  output logic          full,
  output out_item_t     result,
  output logic          empty,
  input  wire logic     pop
);

  job_req_t front_req;
  logic     accept;
  logic     take;
  logic     has_job;
  job_t     head;

  assign accept = push && !full;

  scbp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .req    (front_req)
  );

  scbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_req),
    .full    (full),
    .take    (take),
    .has_job (has_job),
    .head    (head)
  );

  scbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .has_job (has_job),
    .head    (head),
    .take    (take),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule : short_count_bit_packer
`default_nettype wire
